// ----- rtl/ebd_pkg.sv -----
// Shared types and constants for the encoder and button event decoder.
`default_nettype none

package ebd_pkg;

    // Result codes
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_CW         = 3'd1,
        EV_CCW        = 3'd2,
        EV_ENC_PRESS  = 3'd3,
        EV_BACK       = 3'd4,
        EV_CLEAR      = 3'd5,
        EV_CLEAR_LONG = 3'd6
    } t_event;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [1:0] CFG_DETENT     = 2'd2;

    localparam int CFG_WIDTH = 16;

    localparam logic [7:0]  DEBOUNCE_RST   = 8'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [3:0]  DETENT_RST     = 4'd4;

    // Gray-code transitions {last phase, new phase}, A in the high bit
    localparam logic [3:0] TR_UP_0 = 4'b0001;
    localparam logic [3:0] TR_UP_1 = 4'b0111;
    localparam logic [3:0] TR_UP_2 = 4'b1110;
    localparam logic [3:0] TR_UP_3 = 4'b1000;
    localparam logic [3:0] TR_DN_0 = 4'b0010;
    localparam logic [3:0] TR_DN_1 = 4'b1011;
    localparam logic [3:0] TR_DN_2 = 4'b1101;
    localparam logic [3:0] TR_DN_3 = 4'b0100;

    // Named buttons: encoder switch, back, clear
    localparam int NAMED_BUTTONS = 3;

    typedef struct packed {
        logic en;          // run the debounce update this beat
        logic take_short;  // short event given, drop it
        logic take_long;   // long event given, drop it
    } t_btn_ctl;

    typedef struct packed {
        logic short_pend;
        logic long_rep;
    } t_btn_stat;

endpackage

`default_nettype wire

// ----- rtl/ebd_quad.sv -----
// Quadrature transition decoder with saturating count and detent poll.
`default_nettype none

module ebd_quad
    import ebd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_op,
    input  wire logic [1:0] i_phase,
    input  wire logic [3:0] i_cpd,
    output t_event          o_rot
);

    logic        [1:0] r_phase;
    logic signed [7:0] r_count;
    logic signed [7:0] n_count;

    logic        [3:0] w_tr;
    logic signed [8:0] w_sum;
    logic signed [8:0] w_dec;
    logic signed [8:0] w_cpd;
    logic signed [8:0] w_res;

    always_comb begin
        w_tr  = {r_phase, i_phase};
        w_sum = {r_count[7], r_count};
        unique case (w_tr)
            TR_UP_0, TR_UP_1, TR_UP_2, TR_UP_3: w_sum = {r_count[7], r_count} + 9'sd1;
            TR_DN_0, TR_DN_1, TR_DN_2, TR_DN_3: w_sum = {r_count[7], r_count} - 9'sd1;
            default: w_sum = {r_count[7], r_count};
        endcase
        // saturate at the 8-bit signed range
        if (w_sum > 9'sd127) begin
            w_dec = 9'sd127;
        end else if (w_sum < -9'sd128) begin
            w_dec = -9'sd128;
        end else begin
            w_dec = w_sum;
        end
    end

    always_comb begin
        // a detent setting of zero acts as one
        w_cpd = (i_cpd == 4'd0) ? 9'sd1 : $signed({5'b0, i_cpd});
        w_res = w_dec;
        o_rot = EV_NONE;
        if (i_op) begin
            if (w_dec >= w_cpd) begin
                o_rot = EV_CW;
                w_res = w_dec - w_cpd;
            end else if (w_dec <= -w_cpd) begin
                o_rot = EV_CCW;
                w_res = w_dec + w_cpd;
            end
        end
        n_count = w_res[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'b00;
            r_count <= 8'sd0;
        end else if (i_step) begin
            r_phase <= i_phase;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ebd_button.sv -----
// Timestamp debounce and short/long press tracking for one button.
`default_nettype none

module ebd_button
    import ebd_pkg::*;
#(
    parameter bit IS_CLEAR = 1'b0
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_btn_ctl    i_ctl,
    input  wire logic        i_level,
    input  wire logic [31:0] i_now,
    input  wire logic [7:0]  i_debounce,
    input  wire logic [15:0] i_long_ms,
    output t_btn_stat        o_stat
);

    logic        r_level;
    logic [31:0] r_change;
    logic [31:0] r_press;
    logic        r_held;
    logic        r_sp;
    logic        r_lf;
    logic        r_lr;

    logic        n_level;
    logic [31:0] n_change;
    logic [31:0] n_press;
    logic        n_held;
    logic        n_sp;
    logic        n_lf;
    logic        n_lr;

    logic        w_changed;
    logic        w_stable;
    logic        w_down;
    logic [31:0] w_age;
    logic [31:0] w_hold;

    always_comb begin
        n_level  = r_level;
        n_change = r_change;
        n_press  = r_press;
        n_held   = r_held;
        n_sp     = r_sp;
        n_lf     = r_lf;
        n_lr     = r_lr;

        w_changed = (i_level != r_level);
        w_age     = i_now - r_change;
        w_hold    = i_now - r_press;
        // a fresh level change restarts the window, so it is never stable yet
        w_stable  = !w_changed && (w_age > {24'b0, i_debounce});
        w_down    = !i_level;

        if (i_ctl.en) begin
            n_level = i_level;
            if (w_changed) begin
                n_change = i_now;
            end
            if (w_stable) begin
                if (w_down && !r_held && !r_sp) begin
                    n_held  = 1'b1;
                    n_press = i_now;
                end else if (w_down && r_held && !r_lf) begin
                    if (w_hold > {16'b0, i_long_ms}) begin
                        n_lf = 1'b1;
                        if (IS_CLEAR) begin
                            n_lr = 1'b1;
                        end
                    end
                end else if (!w_down && r_held) begin
                    if (!r_lf) begin
                        n_sp = 1'b1;
                    end
                    n_held = 1'b0;
                    n_lf   = 1'b0;
                end
            end
        end
    end

    assign o_stat.short_pend = n_sp;
    assign o_stat.long_rep   = n_lr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 1'b1;
            r_change <= '0;
            r_press  <= '0;
            r_held   <= 1'b0;
            r_sp     <= 1'b0;
            r_lf     <= 1'b0;
            r_lr     <= 1'b0;
        end else begin
            r_level  <= n_level;
            r_change <= n_change;
            r_press  <= n_press;
            r_held   <= n_held;
            r_sp     <= n_sp & ~i_ctl.take_short;
            r_lf     <= n_lf;
            r_lr     <= n_lr & ~i_ctl.take_long;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/encoder_and_button_event_decoder_core.sv -----
// An accepted input beat passes the input register and then the result register; a stalled output can hold it between.
// Throughput: one beat per cycle unless stalled; the next beat is taken while a result waits in the output register.
// The rate is set by the single state update pass (count, clock, debounce) between the two registers.
// Reset (synchronous, active low) clears count, phase, time and button state; buttons read released.
// Configuration registers reset to debounce 50 ms, long press 1000 ms, 4 counts per detent.
`default_nettype none

module encoder_and_button_event_decoder_core
    import ebd_pkg::*;
#(
    parameter int NUM_BUTTONS = 3
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_op,
    input  wire logic                 i_enc_a,
    input  wire logic                 i_enc_b,
    input  wire logic                 i_enc_switch,
    input  wire logic                 i_back_level,
    input  wire logic                 i_clear_level,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [2:0]                o_event_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0] i_cfg_data
);

    // configuration
    logic [7:0]  r_debounce;
    logic [15:0] r_long_ms;
    logic [3:0]  r_cpd;

    // input register
    logic        r_in_valid;
    logic        r_op;
    logic [1:0]  r_phase;
    logic [NAMED_BUTTONS-1:0] r_lvl;

    // time, held as millis_now + 1 so a tick reads it directly
    logic [31:0] r_now;

    // result register
    logic        r_out_valid;
    t_event      r_event;

    logic        w_step;
    logic        w_btn_en;
    t_event      w_rot;
    t_event      w_ev;
    logic [NAMED_BUTTONS-1:0] w_sp;
    logic [NAMED_BUTTONS-1:0] w_lr;
    logic [NAMED_BUTTONS-1:0] w_take_s;
    logic [NAMED_BUTTONS-1:0] w_take_l;

    t_btn_ctl  w_ctl  [NUM_BUTTONS];
    t_btn_stat w_stat [NUM_BUTTONS];

    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_long_ms  <= LONG_PRESS_RST;
            r_cpd      <= DETENT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:   r_debounce <= i_cfg_data[7:0];
                CFG_LONG_PRESS: r_long_ms  <= i_cfg_data[15:0];
                CFG_DETENT:     r_cpd      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op    <= i_op;
            r_phase <= {i_enc_a, i_enc_b};
            r_lvl   <= {i_clear_level, i_back_level, i_enc_switch};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= 32'd1;
        end else if (w_step && r_op) begin
            r_now <= r_now + 32'd1;
        end
    end

    ebd_quad u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_op    (r_op),
        .i_phase (r_phase),
        .i_cpd   (r_cpd),
        .o_rot   (w_rot)
    );

    // a detent event skips the buttons for this tick
    assign w_btn_en = w_step && r_op && (w_rot == EV_NONE);

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        logic w_level;
        if (b < NAMED_BUTTONS) begin : g_named
            assign w_level          = r_lvl[b];
            assign w_ctl[b].take_short = w_take_s[b];
            assign w_ctl[b].take_long  = w_take_l[b];
        end else begin : g_extra
            assign w_level          = 1'b1;
            assign w_ctl[b].take_short = 1'b0;
            assign w_ctl[b].take_long  = 1'b0;
        end
        assign w_ctl[b].en = w_btn_en;

        ebd_button #(
            .IS_CLEAR (b == 2)
        ) u_button (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[b]),
            .i_level    (w_level),
            .i_now      (r_now),
            .i_debounce (r_debounce),
            .i_long_ms  (r_long_ms),
            .o_stat     (w_stat[b])
        );
    end

    for (genvar k = 0; k < NAMED_BUTTONS; k++) begin : g_named_stat
        if (k < NUM_BUTTONS) begin : g_on
            assign w_sp[k] = w_stat[k].short_pend;
            assign w_lr[k] = w_stat[k].long_rep;
        end else begin : g_off
            assign w_sp[k] = 1'b0;
            assign w_lr[k] = 1'b0;
        end
    end

    // fixed priority: detent rotation, encoder press, back, clear long, clear short
    always_comb begin
        w_ev     = EV_NONE;
        w_take_s = '0;
        w_take_l = '0;
        if (w_step && r_op) begin
            if (w_rot != EV_NONE) begin
                w_ev = w_rot;
            end else if (w_sp[0]) begin
                w_ev        = EV_ENC_PRESS;
                w_take_s[0] = 1'b1;
            end else if (w_sp[1]) begin
                w_ev        = EV_BACK;
                w_take_s[1] = 1'b1;
            end else if (w_lr[2]) begin
                w_ev        = EV_CLEAR_LONG;
                w_take_l[2] = 1'b1;
            end else if (w_sp[2]) begin
                w_ev        = EV_CLEAR;
                w_take_s[2] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_event <= w_ev;
        end
    end

    a_sample_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !r_op) |=> (o_event_res == EV_NONE))
        else $error("sample-only beat produced an event");

    a_time_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_step && r_op) |=> $stable(r_now))
        else $error("time advanced without a tick beat");

    a_detent_skips_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rot != EV_NONE) |-> !w_btn_en)
        else $error("buttons updated on a detent tick");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room downstream");

endmodule

`default_nettype wire
